// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while the block is out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Types, codes and constants of the telemetry sentence parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int TAG_MAX_LENGTH_DEF = 19;
	localparam logic [7:0] LOW_BATTERY_LIMIT_RST = 8'd15;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 64;

	// Tag words, first character in the top byte.
	localparam logic [31:0] TAG_WORD_DATA = 32'h44415441;
	localparam logic [31:0] TAG_WORD_WARN = 32'h5741524E;
	localparam logic [31:0] TAG_WORD_ERR = 32'h45525200;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [31:0] MAG_CAP = 32'h8000_0000;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_LOW_BATTERY = 2'd1,
		ST_MALFORMED   = 2'd2,
		ST_UNKNOWN_TAG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TAG_NONE = 2'd0,
		TAG_DATA = 2'd1,
		TAG_WARN = 2'd2,
		TAG_ERR  = 2'd3
	} tag_code_t;

	typedef enum logic [2:0] {
		PH_TAG    = 3'b001,
		PH_FIELDS = 3'b010,
		PH_ENDED  = 3'b100
	} phase_t;

	typedef enum logic [3:0] {
		NP_SKIP   = 4'b0001,
		NP_SIGN   = 4'b0010,
		NP_DIGITS = 4'b0100,
		NP_DONE   = 4'b1000
	} num_phase_t;

	typedef struct packed {
		logic [31:0] timestamp;
		logic        last_byte;
		logic [7:0]  data_byte;
	} beat_t;

	typedef struct packed {
		logic [31:0] stamp_out;
		logic [1:0]  fields_seen;
		logic [7:0]  battery;
		logic [7:0]  satellites;
		logic [7:0]  speed;
		tag_code_t   tag_code;
		status_t     status;
	} result_t;

endpackage

// ===== rtl/tsp_parser.sv =====
// ----------------------------------------------------------------------------
// tsp_parser
// Sentence state and the per-byte update: tokenizer, tag match, number
// conversion and the first-decision status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsp_parser #(
	parameter int TAG_MAX_LENGTH = tsp_pkg::TAG_MAX_LENGTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tsp_pkg::beat_t   beat,
	input  logic [7:0]       low_battery_limit,
	output tsp_pkg::result_t result
);

	localparam int TLEN_W = $clog2(TAG_MAX_LENGTH + 2);

	typedef struct packed {
		tsp_pkg::phase_t     phase;
		logic                token_active;
		logic [TLEN_W-1:0]   tag_length;
		logic [31:0]         tag_chars;
		logic [1:0]          field_index;
		tsp_pkg::num_phase_t num_phase;
		logic [31:0]         magnitude;
		logic                negative;
		logic [7:0]          speed;
		logic [7:0]          satellites;
		logic [7:0]          battery;
		tsp_pkg::tag_code_t  tag;
		tsp_pkg::status_t    status;
		logic                decided;
		logic [31:0]         stamp;
		logic                in_sentence;
	} state_t;

	state_t st_q;
	state_t st_d;

	function automatic state_t clear_token(state_t s);
		state_t r;
		r = s;
		r.token_active = 1'b0;
		r.tag_length = '0;
		r.tag_chars = '0;
		r.num_phase = tsp_pkg::NP_SKIP;
		r.magnitude = '0;
		r.negative = 1'b0;
		return r;
	endfunction

	function automatic state_t clear_sentence();
		state_t r;
		r = '0;
		r = clear_token(r);
		r.phase = tsp_pkg::PH_TAG;
		r.tag = tsp_pkg::TAG_NONE;
		r.status = tsp_pkg::ST_OK;
		return r;
	endfunction

	function automatic state_t decide(state_t s, tsp_pkg::status_t code);
		state_t r;
		r = s;
		r.status = code;
		r.decided = 1'b1;
		return r;
	endfunction

	function automatic state_t end_token(state_t s, logic [7:0] lim);
		state_t r;
		logic [7:0] lo;
		logic low;
		r = s;
		// Saturated value: a negative magnitude never exceeds 2^31.
		if (s.negative) begin
			lo = 8'(32'd0 - s.magnitude);
		end else if (s.magnitude == tsp_pkg::MAG_CAP) begin
			lo = 8'hFF;
		end else begin
			lo = s.magnitude[7:0];
		end
		low = s.negative || (s.magnitude <= {24'd0, lim});
		case (s.phase)
			tsp_pkg::PH_TAG: begin
				if (s.tag_length > TLEN_W'(TAG_MAX_LENGTH)) begin
					r = decide(r, tsp_pkg::ST_MALFORMED);
				end else if (s.tag_length == TLEN_W'(4) &&
				             s.tag_chars == tsp_pkg::TAG_WORD_DATA) begin
					r.tag = tsp_pkg::TAG_DATA;
					r.phase = tsp_pkg::PH_FIELDS;
				end else if (s.tag_length == TLEN_W'(4) &&
				             s.tag_chars == tsp_pkg::TAG_WORD_WARN) begin
					r.tag = tsp_pkg::TAG_WARN;
					r.phase = tsp_pkg::PH_FIELDS;
				end else if (s.tag_length == TLEN_W'(3) &&
				             s.tag_chars == tsp_pkg::TAG_WORD_ERR) begin
					r.tag = tsp_pkg::TAG_ERR;
					r.phase = tsp_pkg::PH_FIELDS;
				end else begin
					r = decide(r, tsp_pkg::ST_UNKNOWN_TAG);
				end
			end
			tsp_pkg::PH_FIELDS: begin
				if (s.field_index == 2'd3) begin
					r = decide(r, tsp_pkg::ST_MALFORMED);
				end else begin
					case (s.field_index)
						2'd0: r.speed = lo;
						2'd1: r.satellites = lo;
						default: begin
							r.battery = lo;
							if (low) begin
								r = decide(r, tsp_pkg::ST_LOW_BATTERY);
							end
						end
					endcase
					r.field_index = s.field_index + 2'd1;
				end
			end
			default: ;
		endcase
		return clear_token(r);
	endfunction

	function automatic state_t add_digit(state_t s, logic [7:0] c);
		state_t r;
		logic [35:0] w;
		logic [35:0] m;
		logic [7:0] d;
		r = s;
		d = c - tsp_pkg::CH_ZERO;
		w = {4'd0, s.magnitude};
		m = (w << 3) + (w << 1) + {32'd0, d[3:0]};
		r.magnitude = (m > {4'd0, tsp_pkg::MAG_CAP}) ? tsp_pkg::MAG_CAP : m[31:0];
		r.num_phase = tsp_pkg::NP_DIGITS;
		return r;
	endfunction

	function automatic state_t number_char(state_t s, logic [7:0] c);
		state_t r;
		logic digit;
		logic ws;
		r = s;
		digit = c inside {[tsp_pkg::CH_ZERO:tsp_pkg::CH_NINE]};
		ws = c inside {tsp_pkg::CH_SPACE, [tsp_pkg::CH_TAB:tsp_pkg::CH_CR]};
		case (s.num_phase)
			tsp_pkg::NP_SKIP: begin
				if (ws) begin
					r = s;
				end else if (c == tsp_pkg::CH_PLUS) begin
					r.num_phase = tsp_pkg::NP_SIGN;
				end else if (c == tsp_pkg::CH_MINUS) begin
					r.negative = 1'b1;
					r.num_phase = tsp_pkg::NP_SIGN;
				end else if (digit) begin
					r = add_digit(s, c);
				end else begin
					r.num_phase = tsp_pkg::NP_DONE;
				end
			end
			tsp_pkg::NP_SIGN, tsp_pkg::NP_DIGITS: begin
				if (digit) begin
					r = add_digit(s, c);
				end else begin
					r.num_phase = tsp_pkg::NP_DONE;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always_comb begin
		state_t n;
		logic [7:0] c;
		n = st_q;
		c = beat.data_byte;
		if (!n.in_sentence) begin
			n.stamp = beat.timestamp;
			n.in_sentence = 1'b1;
		end
		if (!n.decided && n.phase != tsp_pkg::PH_ENDED) begin
			if (c == tsp_pkg::CH_NUL) begin
				// NUL ends the text; the rest of the sentence is ignored.
				if (n.token_active) begin
					n = end_token(n, low_battery_limit);
				end
				if (!n.decided && n.phase == tsp_pkg::PH_TAG) begin
					n = decide(n, tsp_pkg::ST_MALFORMED);
				end
				n.phase = tsp_pkg::PH_ENDED;
			end else if (c inside {tsp_pkg::CH_DOLLAR, tsp_pkg::CH_COMMA, tsp_pkg::CH_HASH}) begin
				if (n.token_active) begin
					n = end_token(n, low_battery_limit);
				end
			end else begin
				n.token_active = 1'b1;
				if (n.phase == tsp_pkg::PH_TAG) begin
					if (n.tag_length < TLEN_W'(4)) begin
						case (n.tag_length[1:0])
							2'd0: n.tag_chars[31:24] = c;
							2'd1: n.tag_chars[23:16] = c;
							2'd2: n.tag_chars[15:8] = c;
							default: n.tag_chars[7:0] = c;
						endcase
					end
					if (n.tag_length <= TLEN_W'(TAG_MAX_LENGTH)) begin
						n.tag_length = n.tag_length + TLEN_W'(1);
					end
				end else begin
					n = number_char(n, c);
				end
			end
		end
		if (beat.last_byte && !n.decided) begin
			if (n.token_active) begin
				n = end_token(n, low_battery_limit);
			end
			if (!n.decided && n.phase == tsp_pkg::PH_TAG) begin
				n = decide(n, tsp_pkg::ST_MALFORMED);
			end
		end
		result.status = n.decided ? n.status : tsp_pkg::ST_OK;
		result.tag_code = n.tag;
		result.speed = n.speed;
		result.satellites = n.satellites;
		result.battery = n.battery;
		result.fields_seen = n.field_index;
		result.stamp_out = n.stamp;
		st_d = beat.last_byte ? clear_sentence() : n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clear_sentence();
		end else if (en) begin
			st_q <= st_d;
		end
	end

	`ASSERT_CLK(a_decided_status, clk, arst_n,
		st_q.decided == (st_q.status != tsp_pkg::ST_OK), "status set without a decision")
	`ASSERT_IMPL(a_fields_have_tag, clk, arst_n, st_q.phase == tsp_pkg::PH_FIELDS,
		st_q.tag != tsp_pkg::TAG_NONE, "field phase entered without a valid tag")
	`ASSERT_CLK(a_mag_capped, clk, arst_n, st_q.magnitude <= tsp_pkg::MAG_CAP,
		"number accumulator exceeded its saturation limit")

endmodule

// ===== rtl/telemetry_sentence_parser_top.sv =====
// ----------------------------------------------------------------------------
// telemetry_sentence_parser_top
// Parses telemetry sentences delivered one ASCII character per input beat
// and returns one result beat per sentence, on the beat marked by s_tlast.
// The block accepts one character beat per clock cycle unless a final
// character is stalled in the input register. Each beat is registered, then
// the combinational parser logic updates the sentence state and, for the last
// character, loads the output register. Only a last character waits while an
// unread result occupies the output register; other characters keep flowing.
// The low battery limit resets to 15 and may be written through
// cfg_we/cfg_wdata while no sentence is in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module telemetry_sentence_parser_top #(
	parameter int TAG_MAX_LENGTH = tsp_pkg::TAG_MAX_LENGTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// data_byte [7:0], timestamp [39:8]
	input  logic [tsp_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// status [1:0], tag_code [3:2], speed [11:4], satellites [19:12],
	// battery [27:20], fields_seen [29:28], stamp_out [61:30], zero [63:62]
	output logic [tsp_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_wdata
);

	tsp_pkg::beat_t   beat_s1;
	logic             valid_s1;
	tsp_pkg::result_t result_c;
	tsp_pkg::result_t result_q;
	logic             m_tvalid_q;
	logic [7:0]       low_battery_limit_q;
	logic             fire;

	// A non-final character needs no room at the output.
	assign fire = valid_s1 && (!beat_s1.last_byte || !m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1.data_byte <= s_tdata[7:0];
			beat_s1.timestamp <= s_tdata[39:8];
			beat_s1.last_byte <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_battery_limit_q <= tsp_pkg::LOW_BATTERY_LIMIT_RST;
		end else if (cfg_we) begin
			low_battery_limit_q <= cfg_wdata;
		end
	end

	tsp_parser #(
		.TAG_MAX_LENGTH(TAG_MAX_LENGTH)
	) u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (fire),
		.beat              (beat_s1),
		.low_battery_limit (low_battery_limit_q),
		.result            (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire && beat_s1.last_byte) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && beat_s1.last_byte) begin
			result_q <= result_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {2'b00, result_q.stamp_out, result_q.fields_seen, result_q.battery,
		result_q.satellites, result_q.speed, result_q.tag_code, result_q.status};

	`ASSERT_CLK(a_result_loaded, clk, arst_n,
		(fire && beat_s1.last_byte) |=> m_tvalid_q, "final beat did not raise a result")
	`ASSERT_IMPL(a_no_overwrite, clk, arst_n,
		m_tvalid_q && !m_tready && valid_s1 && beat_s1.last_byte, !fire,
		"pending result would be overwritten")
	`ASSERT_CLK(a_stage_holds, clk, arst_n,
		(valid_s1 && !fire) |=> (valid_s1 && $stable(beat_s1)), "stalled input stage changed")

endmodule
